[sv/hcb_pkg.sv]
// Shared types and constants for the Huffman code builder.
// No dependencies; every other file uses this package.
`default_nettype none
package hcb_pkg;
    localparam int MAX_LEAVES_DEF  = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int LEAF_W          = 16;
    localparam int CODE_W          = 63;
    localparam int LEN_W           = 6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic build_start;
        logic init_step;
        logic merge_init;
        logic scan_start;
        logic scan_step;
        logic mrg_a;
        logic mrg_b;
        logic mrg_c;
        logic walk_init;
        logic walk_start;
        logic walk_head;
        logic walk_read;
        logic walk_eval;
        logic emit_load;
        logic emit_next;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic init_done;
        logic single;
        logic scan_done;
        logic merges_done;
        logic at_root;
        logic last_leaf;
    } t_sts;
endpackage
`default_nettype wire

[sv/hcb_if.sv]
// Valid/ready channel interfaces for leaf requests and code results.
// Depends on hcb_pkg for the field widths.
`default_nettype none
interface hcb_in_if;
    logic                      valid;
    logic                      ready;
    logic [hcb_pkg::LEAF_W-1:0] leaf_weight;
    logic                      last_leaf;
    modport source (output valid, leaf_weight, last_leaf, input ready);
    modport sink   (input valid, leaf_weight, last_leaf, output ready);
endinterface

interface hcb_out_if;
    logic                      valid;
    logic                      ready;
    logic [hcb_pkg::LEAF_W-1:0] out_weight;
    logic [hcb_pkg::CODE_W-1:0] code_bits;
    logic [hcb_pkg::LEN_W-1:0]  code_length;
    logic                      last_code;
    modport source (output valid, out_weight, code_bits, code_length, last_code,
                    input ready);
    modport sink   (input valid, out_weight, code_bits, code_length, last_code,
                    output ready);
endinterface
`default_nettype wire

[sv/hcb_ctrl.sv]
// Sequencer for load, tree build and code walk.
// Depends on hcb_pkg for the command and status structs.
`default_nettype none
module hcb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_last_leaf,
    input  wire logic          i_out_ready,
    input  wire hcb_pkg::t_sts i_sts,
    output hcb_pkg::t_cmd      o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import hcb_pkg::*;

    typedef enum logic [10:0] {
        S_LOAD    = 11'b000_0000_0001,
        S_INIT    = 11'b000_0000_0010,
        S_SCAN    = 11'b000_0000_0100,
        S_MRG_A   = 11'b000_0000_1000,
        S_MRG_B   = 11'b000_0001_0000,
        S_MRG_C   = 11'b000_0010_0000,
        S_W_START = 11'b000_0100_0000,
        S_W_HEAD  = 11'b000_1000_0000,
        S_W_CHK   = 11'b001_0000_0000,
        S_W_EVAL  = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // decode commands and next state
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_leaf) begin
                        o_cmd.build_start = 1'b1;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (i_sts.init_done) begin
                    o_cmd.merge_init = 1'b1;
                    if (i_sts.single) begin
                        o_cmd.walk_init = 1'b1;
                        n_state = S_W_START;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end else begin
                    o_cmd.init_step = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_MRG_A;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_MRG_A: begin
                o_cmd.mrg_a = 1'b1;
                n_state = S_MRG_B;
            end
            S_MRG_B: begin
                o_cmd.mrg_b = 1'b1;
                n_state = S_MRG_C;
            end
            S_MRG_C: begin
                o_cmd.mrg_c = 1'b1;
                if (i_sts.merges_done) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_W_START;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_W_START: begin
                o_cmd.walk_start = 1'b1;
                n_state = S_W_HEAD;
            end
            S_W_HEAD: begin
                o_cmd.walk_head = 1'b1;
                n_state = S_W_CHK;
            end
            S_W_CHK: begin
                if (i_sts.at_root) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.walk_read = 1'b1;
                    n_state = S_W_EVAL;
                end
            end
            S_W_EVAL: begin
                o_cmd.walk_eval = 1'b1;
                n_state = S_W_CHK;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_next = 1'b1;
                    n_state = i_sts.last_leaf ? S_LOAD : S_W_START;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

[sv/hcb_datapath.sv]
// Node store, two-minimum scan, merge and code walk registers.
// Depends on hcb_pkg; driven by commands from hcb_ctrl.
`default_nettype none
module hcb_datapath #(
    parameter int MAX_LEAVES  = hcb_pkg::MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire hcb_pkg::t_cmd              i_cmd,
    input  wire logic [hcb_pkg::LEAF_W-1:0] i_leaf_weight,
    output hcb_pkg::t_sts                   o_sts,
    output logic [hcb_pkg::LEAF_W-1:0]      o_out_weight,
    output logic [hcb_pkg::CODE_W-1:0]      o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]       o_code_length,
    output logic                            o_last_code
);
    import hcb_pkg::*;

    localparam int NODES = 2 * MAX_LEAVES - 1;
    localparam int IW    = $clog2(2 * MAX_LEAVES);
    localparam int NWW   = WEIGHT_BITS + $clog2(MAX_LEAVES);
    localparam int IN_W  = (WEIGHT_BITS < LEAF_W) ? WEIGHT_BITS : LEAF_W;
    localparam logic [IW-1:0] NO_PARENT = IW'(NODES);
    localparam logic [IW-1:0] MAX_CNT   = IW'(MAX_LEAVES);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CODE_W);

    logic [NWW-1:0] mem_w [NODES];
    logic [IW-1:0]  mem_p [NODES];
    logic [IW-1:0]  mem_l [NODES];

    logic [IW-1:0]  r_count, r_i, r_k, r_sidx, r_s0, r_s1, r_leaf, r_c, r_f;
    logic           r_sv, r_v0, r_v1;
    logic [NWW-1:0] r_w0, r_w1, r_ow;
    logic [NWW-1:0] r_wd;
    logic [IW-1:0]  r_pd, r_ld;
    logic [CODE_W-1:0] r_code;
    logic [LEN_W-1:0]  r_len;

    logic [IW:0]    dbl;
    logic [IW-1:0]  total;
    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    logic           ww_en, wp_en, wl_en;
    logic [IW-1:0]  ww_addr, wp_addr;
    logic [NWW-1:0] ww_data;
    logic [IW-1:0]  wp_data;
    logic           cand;
    logic [NWW+LEAF_W-1:0] ow_ext;

    assign dbl   = {r_count, 1'b0};
    assign total = IW'(dbl - 1'b1);

    // select the shared read address
    always_comb begin
        rd_en   = i_cmd.scan_step | i_cmd.walk_start | i_cmd.walk_read;
        rd_addr = r_i;
        if (i_cmd.walk_start) begin
            rd_addr = r_leaf;
        end else if (i_cmd.walk_read) begin
            rd_addr = r_f;
        end
    end

    // select write ports
    always_comb begin
        ww_en   = i_cmd.mrg_a | (i_cmd.load & (r_count != MAX_CNT));
        ww_addr = i_cmd.mrg_a ? r_k : r_count;
        ww_data = i_cmd.mrg_a ? NWW'(r_w0 + r_w1) : NWW'(i_leaf_weight[IN_W-1:0]);
        wl_en   = i_cmd.mrg_a;
        wp_en   = i_cmd.init_step | i_cmd.mrg_b | i_cmd.mrg_c;
        wp_addr = r_i;
        wp_data = NO_PARENT;
        if (i_cmd.mrg_b) begin
            wp_addr = r_s0;
            wp_data = r_k;
        end else if (i_cmd.mrg_c) begin
            wp_addr = r_s1;
            wp_data = r_k;
        end
    end

    // node store
    always_ff @(posedge i_clk) begin
        if (ww_en) begin
            mem_w[ww_addr] <= ww_data;
        end
        if (rd_en) begin
            r_wd <= mem_w[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wp_en) begin
            mem_p[wp_addr] <= wp_data;
        end
        if (rd_en) begin
            r_pd <= mem_p[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wl_en) begin
            mem_l[r_k] <= r_s0;
        end
        if (rd_en) begin
            r_ld <= mem_l[rd_addr];
        end
    end

    // count leaves, step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sv    <= 1'b0;
        end else begin
            r_sv <= i_cmd.scan_step;
            if (i_cmd.load && r_count != MAX_CNT) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.emit_next && o_sts.last_leaf) begin
                r_count <= '0;
            end
        end
    end

    assign cand = r_sv && (r_pd == NO_PARENT);

    // scan for the two lightest parentless nodes, then merge
    always_ff @(posedge i_clk) begin
        r_sidx <= r_i;
        if (i_cmd.build_start || i_cmd.scan_start) begin
            r_i <= '0;
        end else if (i_cmd.init_step || i_cmd.scan_step) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.merge_init) begin
            r_k <= r_count;
        end else if (i_cmd.mrg_c) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.scan_start) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (cand) begin
            if (!r_v0 || r_w0 > r_wd) begin
                r_w1 <= r_w0;
                r_s1 <= r_s0;
                r_v1 <= r_v0;
                r_w0 <= r_wd;
                r_s0 <= r_sidx;
                r_v0 <= 1'b1;
            end else if (!r_v1 || r_w1 > r_wd) begin
                r_w1 <= r_wd;
                r_s1 <= r_sidx;
                r_v1 <= 1'b1;
            end
        end
    end

    // walk each leaf to the root
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_leaf <= '0;
        end else if (i_cmd.emit_next) begin
            r_leaf <= r_leaf + 1'b1;
        end
        if (i_cmd.walk_start) begin
            r_c    <= r_leaf;
            r_code <= '0;
            r_len  <= '0;
        end
        if (i_cmd.walk_head) begin
            r_ow <= r_wd;
            r_f  <= r_pd;
        end
        if (i_cmd.walk_eval) begin
            if (r_ld != r_c) begin
                r_code <= r_code | (CODE_W'(1) << r_len);
            end
            r_len <= r_len + 1'b1;
            r_c   <= r_f;
            r_f   <= r_pd;
        end
    end

    assign ow_ext = {{LEAF_W{1'b0}}, r_ow};

    // hold the finished result
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_out_weight  <= ow_ext[LEAF_W-1:0];
            o_code_bits   <= r_code;
            o_code_length <= r_len;
            o_last_code   <= o_sts.last_leaf;
        end
    end

    // report status
    always_comb begin
        o_sts.init_done   = (r_i == total);
        o_sts.single      = (r_count == IW'(1));
        o_sts.scan_done   = (r_i == r_k);
        o_sts.merges_done = ((r_k + 1'b1) == total);
        o_sts.at_root     = (r_f == NO_PARENT) || (r_len == LEN_MAX);
        o_sts.last_leaf   = (r_leaf == (r_count - 1'b1));
    end
endmodule
`default_nettype wire

[sv/huffman_code_builder_top.sv]
// Huffman code builder: leaf request channel in, code result channel out.
//
// Usage: send leaf weights on i_leaf one request at a time; the request with
// last_leaf set ends the block and starts the build. Up to MAX_LEAVES leaves
// are kept; further weights are dropped. Weights are taken to WEIGHT_BITS.
// i_leaf.ready stays high while loading. After the final leaf the block
// holds i_leaf.ready low while it builds: it marks every node parentless,
// then for each new node k (N..2N-2) scans nodes 0..k-1 one at a time over
// the single read port of the node store and merges in MRG_A, MRG_B, MRG_C.
// Then each leaf is walked to the root, one parent per W_EVAL, and presented
// on o_code, one result per leaf in load order, the final one with
// last_code set. A single leaf gets an empty code.
// A result stays on o_code until o_code.ready is high; the walk of the next
// leaf starts only after that, so a stalled receiver stalls the block.
// After the final result the block accepts a new block of leaves.
// Reset (synchronous, i_rst_n low) empties the leaf count and returns to
// loading; the node store needs no clearing.
// Depends on hcb_pkg, hcb_if, hcb_ctrl and hcb_datapath.
`default_nettype none
module huffman_code_builder_top #(
    parameter int MAX_LEAVES  = hcb_pkg::MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hcb_in_if.sink    i_leaf,
    hcb_out_if.source o_code
);
    import hcb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_leaf.valid),
        .i_last_leaf (i_leaf.last_leaf),
        .i_out_ready (o_code.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (i_leaf.ready),
        .o_out_valid (o_code.valid)
    );

    hcb_datapath #(
        .MAX_LEAVES  (MAX_LEAVES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_leaf_weight (i_leaf.leaf_weight),
        .o_sts         (sts),
        .o_out_weight  (o_code.out_weight),
        .o_code_bits   (o_code.code_bits),
        .o_code_length (o_code.code_length),
        .o_last_code   (o_code.last_code)
    );
endmodule
`default_nettype wire

[tb/huffman_code_builder_top_tb.sv]
// Testbench for the Huffman code builder: leaf requests in, per-leaf codes out.
// Depends on hcb_pkg, hcb_if and huffman_code_builder_top; predicts codes itself.
`timescale 1ns / 1ps
module huffman_code_builder_top_tb;
    import hcb_pkg::*;

    localparam int NLEAF   = MAX_LEAVES_DEF;
    localparam int NNODE   = 2 * NLEAF - 1;
    localparam int NOPAR   = 2 * NLEAF - 1;
    localparam int LIMIT   = 3000000;

    typedef struct packed {
        logic [LEAF_W-1:0] weight;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_code;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    hcb_in_if  leaf_ch ();
    hcb_out_if code_ch ();

    huffman_code_builder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_leaf  (leaf_ch.sink),
        .o_code  (code_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // tree model state
    logic [63:0] tree_wt [NNODE];
    int          tree_par [NNODE];
    int          tree_lft [NNODE];
    int          loaded;
    t_code       code_q [$];

    int send_idle = 24;
    int recv_idle = 50;
    bit hold_off = 1'b0;
    int errors = 0;
    longint cycles = 0;

    // build the tree over the loaded leaves and queue one code per leaf
    function automatic void build_codes();
        int n, total, k, i, s0, s1, c, f, len;
        logic [63:0] w0, w1, code;
        t_code r;
        n = loaded;
        total = 2 * n - 1;
        for (i = 0; i < total; i++) begin
            tree_par[i] = NOPAR;
            if (i >= n) begin
                tree_wt[i] = 0;
                tree_lft[i] = 0;
            end
        end
        for (k = n; k < total; k++) begin
            w0 = '1; w1 = '1; s0 = 0; s1 = 0;
            for (i = 0; i < k; i++) begin
                if (tree_par[i] != NOPAR) continue;
                if (w0 > tree_wt[i]) begin
                    w1 = w0; s1 = s0; w0 = tree_wt[i]; s0 = i;
                end else if (w1 > tree_wt[i]) begin
                    w1 = tree_wt[i]; s1 = i;
                end
            end
            tree_par[s0] = k;
            tree_par[s1] = k;
            tree_lft[k] = s0;
            tree_wt[k] = tree_wt[s0] + tree_wt[s1];
        end
        for (i = 0; i < n; i++) begin
            code = 0; len = 0; c = i; f = tree_par[i];
            while (f < NNODE && len < 63) begin
                if (tree_lft[f] != c) code |= 64'd1 << len;
                len++;
                c = f;
                f = tree_par[f];
            end
            r.weight = tree_wt[i][LEAF_W-1:0];
            r.code = code[CODE_W-1:0];
            r.len = len[LEN_W-1:0];
            r.last = (i + 1 == n);
            code_q.push_back(r);
        end
        loaded = 0;
    endfunction

    function automatic void predict_leaf(logic [LEAF_W-1:0] w, logic last);
        if (loaded < NLEAF) begin
            tree_wt[loaded] = w;
            tree_lft[loaded] = 0;
            loaded++;
        end
        if (last) build_codes();
    endfunction

    // offer one leaf request, with random gaps before it; valid stays high
    // after the accept so that back-to-back requests need no second drive
    task automatic send_leaf(logic [LEAF_W-1:0] w, logic last);
        while ($urandom_range(99) < send_idle) begin
            leaf_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        leaf_ch.valid <= 1'b1;
        leaf_ch.leaf_weight <= w;
        leaf_ch.last_leaf <= last;
        do @(posedge i_clk); while (!leaf_ch.ready);
        predict_leaf(w, last);
    endtask

    task automatic send_block(int n, int wmax);
        for (int i = 0; i < n; i++)
            send_leaf(LEAF_W'($urandom_range(wmax)), i == n - 1);
    endtask

    // drop valid and wait until every predicted code has come
    task automatic drain();
        leaf_ch.valid <= 1'b0;
        while (code_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // directed: extremes, single leaf, ties, huge sums, skewed weights
    task automatic test_directed();
        send_leaf(16'hFFFF, 1'b1);
        send_leaf(16'h0000, 1'b1);
        send_leaf(16'h0000, 1'b0);
        send_leaf(16'h0000, 1'b1);
        send_leaf(16'hFFFF, 1'b0);
        send_leaf(16'hFFFF, 1'b0);
        send_leaf(16'hFFFF, 1'b0);
        send_leaf(16'h5555, 1'b0);
        send_leaf(16'hAAAA, 1'b1);
        for (int i = 0; i < 6; i++) send_leaf(16'd7, i == 5);
        for (int i = 0; i < 6; i++) send_leaf(16'd1 << (2 * i), i == 5);
        drain();
    endtask

    // full store: every weight the maximum with three leaves too many, then skewed weights for long codes
    task automatic test_full_store();
        for (int i = 0; i < NLEAF + 3; i++) send_leaf(16'hFFFF, i == NLEAF + 2);
        for (int i = 0; i < NLEAF; i++)
            send_leaf(i < 16 ? (16'd1 << i) : 16'hFFFF, i == NLEAF - 1);
        drain();
    endtask

    // random blocks, mostly small
    task automatic test_random(int items);
        int n;
        while (items > 0) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(NLEAF + 4, 2)
                                         : $urandom_range(10, 1);
            send_block(n, $urandom_range(1) ? 65535 : 15);
            items -= n;
        end
    endtask

    // receiver holds off while the sender keeps offering leaves
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        send_block(8, 100);
        send_block(5, 100);
        wait fork;
        drain();
    endtask

    // receiver ready, randomized per cycle
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        code_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
        if (cycles > LIMIT) begin
            $display("huffman_code_builder_top: mismatch");
            $finish;
        end
    end

    // check each accepted code against the oldest prediction
    always @(posedge i_clk) begin
        t_code got, exp_c;
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            got = {code_ch.out_weight, code_ch.code_bits, code_ch.code_length,
                   code_ch.last_code};
            if (code_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected code result %h", got);
            end else begin
                exp_c = code_q.pop_front();
                if (got !== exp_c) begin
                    errors++;
                    if (errors <= 10)
                        $display({"code mismatch: exp w=%h c=%h l=%0d t=%b",
                                  " got w=%h c=%h l=%0d t=%b"},
                                 exp_c.weight, exp_c.code, exp_c.len, exp_c.last,
                                 got.weight, got.code, got.len, got.last);
                end
            end
        end
    end

    initial begin
        leaf_ch.valid = 1'b0;
        leaf_ch.leaf_weight = '0;
        leaf_ch.last_leaf = 1'b0;
        code_ch.ready = 1'b0;
        loaded = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_backpressure();
        test_random(90);
        send_idle = 50; recv_idle = 24;
        test_random(90);
        drain();
        send_idle = 0; recv_idle = 0;
        test_random(90);
        drain();
        if (errors == 0 && code_q.size() == 0)
            $display("huffman_code_builder_top: match");
        else
            $display("huffman_code_builder_top: mismatch");
        $finish;
    end
endmodule
